FILE: design/assert_macros.svh
// Assertion helper macros shared by the reassembler RTL.
// No dependencies; defining NO_ASSERTIONS compiles every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: design/bsr_pkg.sv
// Shared types and fixed widths for the byte stream reassembler.
// No dependencies.
package bsr_pkg;

    localparam int POS_W  = 64;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;

    typedef struct packed {
        logic [POS_W-1:0]  byte_pos;
        logic [BYTE_W-1:0] byte_value;
        logic              has_byte;
        logic [POS_W-1:0]  seg_end;
        logic              last_of_segment;
        logic              eof_mark;
        logic [CNT_W-1:0]  space_free;
    } bsr_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_valid;
        logic              last_of_run;
        logic              stream_ended;
        logic [CNT_W-1:0]  pending_count;
    } bsr_rsp_t;

    // admission decision for one request
    typedef struct packed {
        logic in_window;
        logic eof_hit;
    } bsr_admit_t;

endpackage

FILE: design/bsr_admit.sv
// Admission check for one request: window test, ring slot and eof test.
// Depends on bsr_pkg.
module bsr_admit
    import bsr_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  bsr_req_t                        req,
    input  logic [POS_W-1:0]                head,
    input  logic [$clog2(CAPACITY)-1:0]     base,
    output bsr_admit_t                      flags,
    output logic [$clog2(CAPACITY)-1:0]     slot_idx
);

    localparam int AW = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
    localparam logic [AW:0]      CAP_SUM = (AW+1)'(CAPACITY);

    logic [CNT_W-1:0] win;
    logic [POS_W-1:0] pos_diff;
    logic [POS_W-1:0] end_diff;
    logic [AW:0]      slot_sum;
    logic [AW:0]      slot_wrap;
    logic             pos_ok;
    logic             end_ok;

    assign win      = (req.space_free > CAP_CNT) ? CAP_CNT : req.space_free;
    assign pos_diff = req.byte_pos - head;
    assign end_diff = req.seg_end - head;
    assign pos_ok   = (req.byte_pos >= head) && (pos_diff[POS_W-1:CNT_W] == '0)
                      && (pos_diff[CNT_W-1:0] < win);
    // seg_end behind the head counts as inside
    assign end_ok   = (req.seg_end < head)
                      || ((end_diff[POS_W-1:CNT_W] == '0) && (end_diff[CNT_W-1:0] <= win));

    // offset < CAPACITY, so one conditional subtract folds the ring index
    assign slot_sum  = {1'b0, base} + {1'b0, pos_diff[AW-1:0]};
    assign slot_wrap = slot_sum - CAP_SUM;
    assign slot_idx  = (slot_sum >= CAP_SUM) ? slot_wrap[AW-1:0] : slot_sum[AW-1:0];

    assign flags.in_window = req.has_byte && pos_ok;
    assign flags.eof_hit   = req.last_of_segment && req.eof_mark && end_ok;

endmodule

FILE: design/byte_stream_reassembler.sv
// Top level of the byte stream reassembler: request register, slot memory,
// release sequencer and result register. Depends on bsr_pkg, bsr_admit and
// assert_macros.svh.
//
//  channel | ports                        | moves
//  --------+------------------------------+---------------------------------
//  input   | s_valid s_ready s_data       | one request: a byte + position
//  result  | m_valid m_ready m_data       | released byte(s), one per result
//
// Steps: accept, admit, run scan, then for each released byte a memory read and a
//   result load; when nothing is released an empty result is loaded instead.
// The run scan walks the slot valid flags one per cycle; bytes come out of a
//   single-port-read slot memory one per read.
// Reset clears the valid flags, head, count and eof latch at once; no sweep.
// A result stall holds the sequencer in the load step or the empty-result step; the
//   last result of a request may sit in the result register while the next request is taken.
`include "assert_macros.svh"

module byte_stream_reassembler
    import bsr_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  bsr_req_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output bsr_rsp_t m_data
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_RUN   = CW'(CAPACITY);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EVAL  = 6'b000010,
        ST_COUNT = 6'b000100,
        ST_READ  = 6'b001000,
        ST_LOAD  = 6'b010000,
        ST_NONE  = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    bsr_req_t          req_reg;
    logic [CAPACITY-1:0] valid_reg;
    logic [AW-1:0]     base_reg;
    logic [POS_W-1:0]  head_reg;
    logic [CNT_W-1:0]  pending_reg;
    logic              eof_reg;
    logic [AW-1:0]     scan_ptr_reg;
    logic [CW-1:0]     run_cnt_reg;
    logic [CW-1:0]     rem_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic              m_valid_reg;
    bsr_rsp_t          m_data_reg;

    logic [BYTE_W-1:0] slot_mem [CAPACITY];

    bsr_admit_t        adm;
    logic [AW-1:0]     adm_slot;
    logic              store;
    logic              scan_more;
    logic              out_free;
    logic              res_load;
    logic              rd_en;
    logic [AW-1:0]     base_inc;
    logic [AW-1:0]     scan_inc;
    logic [CNT_W-1:0]  run_ext;
    logic [CNT_W-1:0]  pending_after;
    logic              ended;

    bsr_admit #(
        .CAPACITY (CAPACITY)
    ) u_admit (
        .req      (req_reg),
        .head     (head_reg),
        .base     (base_reg),
        .flags    (adm),
        .slot_idx (adm_slot)
    );

    // a byte lands only in an empty slot inside the window
    assign store     = (state_reg == ST_EVAL) && adm.in_window && !valid_reg[adm_slot];
    assign scan_more = (run_cnt_reg < CAP_RUN) && valid_reg[scan_ptr_reg];
    assign out_free  = !m_valid_reg || m_ready;
    // result register takes a new result (byte or empty marker)
    assign res_load  = ((state_reg == ST_LOAD) || (state_reg == ST_NONE)) && out_free;
    assign rd_en     = (state_reg == ST_READ);
    assign base_inc  = (base_reg == LAST_SLOT) ? '0 : base_reg + 1'b1;
    assign scan_inc  = (scan_ptr_reg == LAST_SLOT) ? '0 : scan_ptr_reg + 1'b1;
    assign run_ext   = CNT_W'(run_cnt_reg);
    assign pending_after = (run_ext > pending_reg) ? '0 : pending_reg - run_ext;
    // pending_reg is already final once the scan is done
    assign ended     = eof_reg && (pending_reg == '0);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Slot memory: written in the admit step, read in the read step. The two
    // never share a cycle, so no bypass is needed.
    always_ff @(posedge aclk) begin
        if (store) begin
            slot_mem[adm_slot] <= req_reg.byte_value;
        end
        if (rd_en) begin
            rdata_reg <= slot_mem[base_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_COUNT;
            ST_COUNT: begin
                if (!scan_more) begin
                    state_next = (run_cnt_reg == '0) ? ST_NONE : ST_READ;
                end
            end
            ST_READ:  state_next = ST_LOAD;
            ST_LOAD: begin
                if (out_free) begin
                    state_next = (rem_reg == '0) ? ST_IDLE : ST_READ;
                end
            end
            ST_NONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            base_reg     <= '0;
            head_reg     <= '0;
            pending_reg  <= '0;
            eof_reg      <= 1'b0;
            scan_ptr_reg <= '0;
            run_cnt_reg  <= '0;
            rem_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;

            // a load refills the register even when the old result leaves
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_EVAL: begin
                    if (store) begin
                        valid_reg[adm_slot] <= 1'b1;
                        pending_reg         <= pending_reg + 1'b1;
                    end
                    if (adm.eof_hit) begin
                        eof_reg <= 1'b1;
                    end
                    scan_ptr_reg <= base_reg;
                    run_cnt_reg  <= '0;
                end
                ST_COUNT: begin
                    if (scan_more) begin
                        scan_ptr_reg <= scan_inc;
                        run_cnt_reg  <= run_cnt_reg + 1'b1;
                    end else begin
                        pending_reg <= pending_after;
                        head_reg    <= head_reg + POS_W'(run_cnt_reg);
                        rem_reg     <= run_cnt_reg;
                    end
                end
                ST_READ: begin
                    valid_reg[base_reg] <= 1'b0;
                    base_reg            <= base_inc;
                    rem_reg             <= rem_reg - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD && out_free) begin
            m_data_reg.out_byte      <= rdata_reg;
            m_data_reg.out_valid     <= 1'b1;
            m_data_reg.last_of_run   <= (rem_reg == '0);
            m_data_reg.stream_ended  <= ended;
            m_data_reg.pending_count <= pending_reg;
        end else if (state_reg == ST_NONE && out_free) begin
            m_data_reg.out_byte      <= '0;
            m_data_reg.out_valid     <= 1'b0;
            m_data_reg.last_of_run   <= 1'b1;
            m_data_reg.stream_ended  <= ended;
            m_data_reg.pending_count <= pending_reg;
        end
    end

    `ASSERT_CLK(a_pending_cap, aclk, aresetn, pending_reg <= CNT_W'(CAPACITY), "pending over capacity")
    `ASSERT_IMPL(a_idle_count, aclk, aresetn, state_reg == ST_IDLE, $countones(valid_reg) == pending_reg, "pending count disagrees with valid flags")
    `ASSERT_IMPL(a_idle_head, aclk, aresetn, state_reg == ST_IDLE, !valid_reg[base_reg], "head slot left valid after release")
    `ASSERT_IMPL(a_run_le_pending, aclk, aresetn, state_reg == ST_COUNT && !scan_more, run_ext <= pending_reg, "run longer than pending bytes")

endmodule

FILE: sim/byte_stream_reassembler_tb.sv
// Self-checking testbench for byte_stream_reassembler: drives requests with
// random idling on both channels and checks every result against its own
// reassembly predictor. Depends on bsr_pkg and the reassembler RTL.
module byte_stream_reassembler_tb
    import bsr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS          = 64;
    localparam int WATCHDOG_LIMIT = 1000;
    // Worst case is a full 64-byte run, plus margin.
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_ITEMS   = 460;

    // Reassembly predictor and queue of results still owed by the block.
    class reassembly_scoreboard;
        bit [7:0]  slot_byte [SLOTS];
        bit        slot_full [SLOTS];
        int        base;
        bit [63:0] head;
        int        pending;
        bit        eof_latched;
        bsr_rsp_t  owed_q [$];
        int        errors;
        int        requests;
        int        results;
        int        longest_run;
        int        ended_results;

        function int outstanding();
            return owed_q.size();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        // Store the byte if it falls in the window, update the eof latch, then
        // release the contiguous run starting at the head.
        function void note_request(bsr_req_t r);
            bit [63:0] window;
            bit [63:0] off;
            int        slot;
            bit [7:0]  run [$];
            bsr_rsp_t  rsp;
            bit        ended;
            requests++;
            window = (r.space_free > SLOTS) ? 64'(SLOTS) : 64'(r.space_free);
            if (r.has_byte && r.byte_pos >= head) begin
                off = r.byte_pos - head;
                if (off < window) begin
                    slot = (base + int'(off)) % SLOTS;
                    if (!slot_full[slot]) begin
                        slot_byte[slot] = r.byte_value;
                        slot_full[slot] = 1'b1;
                        pending++;
                    end
                end
            end
            // overflow-free form of "segment end within the window"
            if (r.last_of_segment && r.eof_mark &&
                (r.seg_end < head || r.seg_end - head <= window))
                eof_latched = 1'b1;
            while (run.size() < SLOTS && slot_full[base]) begin
                run = {run, slot_byte[base]};
                slot_full[base] = 1'b0;
                base = (base + 1) % SLOTS;
                head++;
                if (pending > 0) pending--;
            end
            ended = eof_latched && pending == 0;
            if (run.size() > longest_run) longest_run = run.size();
            rsp = '0;
            rsp.stream_ended  = ended;
            rsp.pending_count = 7'(pending);
            if (run.size() == 0) begin
                rsp.last_of_run = 1'b1;
                owed_q = {owed_q, rsp};
            end
            for (int i = 0; i < run.size(); i++) begin
                rsp.out_byte    = run[i];
                rsp.out_valid   = 1'b1;
                rsp.last_of_run = (i == run.size() - 1);
                owed_q = {owed_q, rsp};
            end
        endfunction

        task check_result(bsr_rsp_t got);
            bsr_rsp_t want;
            results++;
            if (owed_q.size() == 0) begin
                report($sformatf("result %h with nothing owed", got));
                return;
            end
            want = owed_q[0];
            owed_q.delete(0);
            if (got.stream_ended === 1'b1) ended_results++;
            if (got.out_byte !== want.out_byte)
                report($sformatf("out_byte %h, want %h", got.out_byte, want.out_byte));
            if (got.out_valid !== want.out_valid)
                report($sformatf("out_valid %b, want %b", got.out_valid, want.out_valid));
            if (got.last_of_run !== want.last_of_run)
                report($sformatf("last_of_run %b, want %b", got.last_of_run,
                                 want.last_of_run));
            if (got.stream_ended !== want.stream_ended)
                report($sformatf("stream_ended %b, want %b", got.stream_ended,
                                 want.stream_ended));
            if (got.pending_count !== want.pending_count)
                report($sformatf("pending_count %0d, want %0d", got.pending_count,
                                 want.pending_count));
        endtask
    endclass

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    bsr_req_t s_data;
    logic     m_valid;
    logic     m_ready;
    bsr_rsp_t m_data;

    reassembly_scoreboard sb = new;

    int send_idle;      // percent of cycles the sender holds off
    int recv_idle;      // percent of cycles the receiver stalls
    int sent;           // requests accepted by the driver so far
    int quiet_cycles;   // cycles since the last handshake on either channel
    bit eof_open;       // once set, random requests may latch end of stream

    byte_stream_reassembler #(.CAPACITY(SLOTS)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver back-pressure: decided at the falling edge, seen at the rising.
    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_idle);
    end

    // Both channels are sampled at the rising edge; requests are noted before
    // results, though no result can belong to a request taken at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_request(s_data);
            if (m_valid && m_ready) sb.check_result(m_data);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    function automatic bsr_req_t make_req(bit [63:0] pos, bit [7:0] value, bit has,
                                          bit [63:0] seg_end, bit last, bit eof,
                                          bit [6:0] space);
        bsr_req_t r;
        r.byte_pos        = pos;
        r.byte_value      = value;
        r.has_byte        = has;
        r.seg_end         = seg_end;
        r.last_of_segment = last;
        r.eof_mark        = eof;
        r.space_free      = space;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request
    // is taken, leaving valid up so the next call can replace the payload in
    // the same step without a low glitch.
    task automatic send(bsr_req_t r);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data  = r;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        sent++;
        @(negedge aclk);
    endtask

    // One segment, one request per byte; a zero length gives an empty segment.
    task automatic send_segment(bit [63:0] first, int n, bit [6:0] space, bit eof);
        if (n == 0)
            send(make_req(first, 8'($urandom), 1'b0, first, 1'b1, eof, space));
        for (int i = 0; i < n; i++)
            send(make_req(first + i, 8'($urandom), 1'b1, first + n, i == n - 1, eof,
                          space));
    endtask

    // A short stretch of stream cut into segments that arrive shuffled, some
    // retransmitted with fresh data (the stored copy must win).
    task automatic send_burst();
        int        len;
        int        gap;
        int        n;
        int        j;
        int        t;
        bit        wide;
        bit [6:0]  space;
        bit [63:0] first;
        int        lo [$];
        int        span [$];
        int        order [$];
        len   = $urandom_range(1, 12);
        gap   = ($urandom_range(99) < 70) ? 0 : $urandom_range(1, 3);
        wide  = ($urandom_range(99) < 75);
        first = sb.head + gap;
        n = 0;
        while (n < len) begin
            t = $urandom_range(1, (len - n < 6) ? len - n : 6);
            lo   = {lo, n};
            span = {span, t};
            n += t;
        end
        for (int i = 0; i < lo.size(); i++) order = {order, i};
        for (int i = order.size() - 1; i > 0; i--) begin
            j = $urandom_range(i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        foreach (order[i]) begin
            space = wide ? 7'(SLOTS) : 7'($urandom_range(127));
            send_segment(first + lo[order[i]], span[order[i]], space, 1'b0);
            if ($urandom_range(99) < 15)
                send_segment(first + lo[order[i]], span[order[i]], space, 1'b0);
        end
    endtask

    // Random fields everywhere, half the time positioned near the head. Until
    // the stream is meant to end, an eof on a last item gets an end far away.
    task automatic send_noise();
        bsr_req_t r;
        r.byte_pos        = $urandom_range(1) ? {$urandom, $urandom}
                                              : sb.head + $urandom_range(70);
        r.byte_value      = 8'($urandom);
        r.has_byte        = 1'($urandom);
        r.seg_end         = {$urandom, $urandom};
        r.last_of_segment = 1'($urandom);
        r.eof_mark        = 1'($urandom);
        r.space_free      = 7'($urandom);
        if (!eof_open && r.last_of_segment && r.eof_mark) r.seg_end[63] = 1'b1;
        send(r);
    endtask

    task automatic run_random(int upto);
        int pick;
        while (sent < upto) begin
            pick = $urandom_range(99);
            if (pick < 72)
                send_burst();
            else if (pick < 80)
                send_segment(sb.head + $urandom_range(4), 0, 7'($urandom_range(127)),
                             1'b0);
            else
                send_noise();
        end
    endtask

    // Fill the window back to front, then the head byte: one 64-byte run.
    task automatic send_full_window();
        bit [63:0] h;
        h = sb.head;
        for (int k = SLOTS - 1; k > 0; k--)
            send(make_req(h + k, 8'($urandom), 1'b1, h + k + 1, 1'b1, 1'b0, 7'(SLOTS)));
        send(make_req(h, 8'($urandom), 1'b1, h + 1, 1'b1, 1'b0, 7'(SLOTS)));
    endtask

    task automatic run_directed();
        bit [63:0] h;
        send(make_req(0, 8'h00, 1'b0, 0, 1'b1, 1'b0, 7'd0));     // empty segment
        send(make_req(0, 8'hFF, 1'b0, 1, 1'b1, 1'b0, 7'd64));    // no byte carried
        send(make_req(0, 8'hFF, 1'b1, 3, 1'b0, 1'b0, 7'd64));    // head byte
        send(make_req(2, 8'h00, 1'b1, 3, 1'b1, 1'b0, 7'h7F));    // ahead, space > cap
        send(make_req(1, 8'hA5, 1'b1, 2, 1'b1, 1'b0, 7'd64));    // gap fill: two out
        h = sb.head;
        send(make_req(h - 2, 8'h11, 1'b1, h - 1, 1'b1, 1'b0, 7'd64));  // behind head
        send(make_req(h + 5, 8'h3C, 1'b1, h + 6, 1'b1, 1'b0, 7'd5));   // past window
        send(make_req(h + 4, 8'hC3, 1'b1, h + 5, 1'b1, 1'b0, 7'd5));   // last in window
        send(make_req(h, 8'h99, 1'b1, h + 1, 1'b1, 1'b0, 7'd0));       // zero window
        send(make_req(64'hFFFF_FFFF_FFFF_FFFF, 8'h5A, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
                      1'b1, 1'b0, 7'h7F));                              // top position
        send(make_req(h + 63, 8'h81, 1'b1, h + 64, 1'b1, 1'b0, 7'd64)); // window edge
        send(make_req(h + 64, 8'h18, 1'b1, h + 65, 1'b1, 1'b0, 7'h7F)); // capped window
        send(make_req(h + 4, 8'h42, 1'b1, h + 5, 1'b1, 1'b0, 7'd64));   // slot occupied
        // eof requests that must not latch
        send(make_req(h, 8'h00, 1'b0, h + 65, 1'b1, 1'b1, 7'd64));      // end past window
        send(make_req(h, 8'h00, 1'b0, h + 6, 1'b1, 1'b1, 7'd5));        // one past edge
        send(make_req(h, 8'h00, 1'b0, h, 1'b0, 1'b1, 7'd64));           // not last item
        send(make_req(h, 8'h00, 1'b0, h, 1'b1, 1'b0, 7'd64));           // no eof mark
        // in-order segment; its last byte also drains the byte stored at h+4
        send_segment(h, 4, 7'd64, 1'b0);
    endtask

    // Latch end of stream with the segment end exactly at the window edge while
    // bytes are still pending, then drain them; finally an eof behind the head.
    task automatic close_stream();
        bit [63:0] h;
        h = sb.head;
        send(make_req(h + 2, 8'($urandom), 1'b1, h + 3, 1'b1, 1'b0, 7'd64));
        send(make_req(h + 1, 8'($urandom), 1'b1, h + 20, 1'b1, 1'b1, 7'd20));
        send(make_req(h, 8'($urandom), 1'b1, h + 1, 1'b1, 1'b0, 7'd64));
        send(make_req(h, 8'h00, 1'b0, 0, 1'b1, 1'b1, 7'd64));
    endtask

    initial begin
        int base_items;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;
        send_idle = 16;
        recv_idle = 59;
        sent      = 0;
        eof_open  = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // phase 1: sender idles lightly, receiver stalls often
        run_directed();
        base_items = sent;
        run_random(base_items + 76);
        send_full_window();
        run_random(base_items + 153);

        // phase 2: the other way round
        send_idle = 59;
        recv_idle = 16;
        run_random(base_items + 230);
        send_full_window();
        run_random(base_items + 306);

        // phase 3: full rate on both sides; the stream ends halfway through
        send_idle = 0;
        recv_idle = 0;
        run_random(base_items + 383);
        close_stream();
        eof_open = 1'b1;
        run_random(base_items + RANDOM_ITEMS);
        s_valid = 1'b0;

        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests and %0d results; longest in-order run %0d bytes",
                 sb.requests, sb.results, sb.longest_run);
        $display("%0d results flagged stream end; %0d mismatches",
                 sb.ended_results, sb.errors);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/bsr_pkg.sv
design/bsr_admit.sv
design/byte_stream_reassembler.sv
sim/byte_stream_reassembler_tb.sv
